// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FUVT_ASSERT_IMP(label, ck, rn, a, c) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define FUVT_ASSERT_NXT(label, ck, rn, a, c) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

// ===== design/fuvt_pkg.sv =====
`default_nettype none

package fuvt_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT_RD,
    ST_HIT_CHK,
    ST_NEW,
    ST_OUT_RD,
    ST_OUT
  } state_t;

  // repeat mark stored per entry; allocated entries start unique
  localparam logic MARK_UNIQUE   = 1'b0;
  localparam logic MARK_REPEATED = 1'b1;

  localparam int KEY_W = 32;

  // result strobe and flags from the sequencer
  typedef struct packed {
    logic valid;
    logic has_unique;
    logic dropped_full;
  } res_flags_t;

endpackage

`default_nettype wire

// ===== design/fuvt_ram.sv =====
`default_nettype none

module fuvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/fuvt_seq.sv =====
`default_nettype none

module fuvt_seq #(
  parameter int CAPACITY = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [fuvt_pkg::KEY_W-1:0]          value,
  output logic                                     busy,
  output logic      [fuvt_pkg::KEY_W-1:0]          first_value,
  output fuvt_pkg::res_flags_t                     flags,
  // key store
  output logic                                     key_we,
  output logic      [$clog2(CAPACITY)-1:0]         key_waddr,
  output logic      [fuvt_pkg::KEY_W-1:0]          key_wdata,
  output logic      [$clog2(CAPACITY)-1:0]         key_raddr,
  input  wire logic [fuvt_pkg::KEY_W-1:0]          key_rdata,
  // repeat marks
  output logic                                     rep_we,
  output logic      [$clog2(CAPACITY)-1:0]         rep_waddr,
  output logic                                     rep_wdata,
  output logic      [$clog2(CAPACITY)-1:0]         rep_raddr,
  input  wire logic                                rep_rdata,
  // next links
  output logic                                     nxt_we,
  output logic      [$clog2(CAPACITY)-1:0]         nxt_waddr,
  output logic      [$clog2(CAPACITY)-1:0]         nxt_wdata,
  output logic      [$clog2(CAPACITY)-1:0]         nxt_raddr,
  input  wire logic [$clog2(CAPACITY)-1:0]         nxt_rdata,
  // prev links
  output logic                                     prv_we,
  output logic      [$clog2(CAPACITY)-1:0]         prv_waddr,
  output logic      [$clog2(CAPACITY)-1:0]         prv_wdata,
  output logic      [$clog2(CAPACITY)-1:0]         prv_raddr,
  input  wire logic [$clog2(CAPACITY)-1:0]         prv_rdata
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  fuvt_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                used_r, used_nxt;
  logic [IW-1:0]                head_r, head_nxt;
  logic [IW-1:0]                tail_r, tail_nxt;
  logic                         nonempty_r, nonempty_nxt;
  logic                         pend_r, pend_nxt;
  logic [CW-1:0]                scan_r, scan_nxt;
  logic [IW-1:0]                last_r, last_nxt;
  logic [IW-1:0]                hit_r, hit_nxt;
  logic [fuvt_pkg::KEY_W-1:0]   value_r, value_nxt;
  logic                         dropped_r, dropped_nxt;

  logic issue;
  logic is_head;
  logic is_tail;
  logic [IW-1:0] new_idx;

  assign issue   = (scan_r < used_r);
  assign is_head = (hit_r == head_r);
  assign is_tail = (hit_r == tail_r);
  assign new_idx = used_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fuvt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      nonempty_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      nonempty_r <= nonempty_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    last_r    <= last_nxt;
    hit_r     <= hit_nxt;
    value_r   <= value_nxt;
    dropped_r <= dropped_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    nonempty_nxt = nonempty_r;
    pend_nxt     = 1'b0;
    scan_nxt     = scan_r;
    last_nxt     = last_r;
    hit_nxt      = hit_r;
    value_nxt    = value_r;
    dropped_nxt  = dropped_r;

    key_we    = 1'b0;
    key_waddr = new_idx;
    key_wdata = value_r;
    key_raddr = scan_r[IW-1:0];
    rep_we    = 1'b0;
    rep_waddr = new_idx;
    rep_wdata = fuvt_pkg::MARK_UNIQUE;
    rep_raddr = hit_r;
    nxt_we    = 1'b0;
    nxt_waddr = tail_r;
    nxt_wdata = new_idx;
    nxt_raddr = hit_r;
    prv_we    = 1'b0;
    prv_waddr = new_idx;
    prv_wdata = tail_r;
    prv_raddr = hit_r;

    busy  = (state_r != fuvt_pkg::ST_IDLE);
    flags = '{valid: 1'b0, has_unique: nonempty_r, dropped_full: dropped_r};

    case (state_r)
      fuvt_pkg::ST_IDLE: begin
        if (start) begin
          value_nxt   = value;
          scan_nxt    = '0;
          dropped_nxt = 1'b0;
          state_nxt   = fuvt_pkg::ST_SCAN;
        end
      end
      fuvt_pkg::ST_SCAN: begin
        // one key read issued per cycle, compared in the cycle after its issue
        pend_nxt = issue;
        scan_nxt = scan_r + CW'(issue);
        last_nxt = scan_r[IW-1:0];
        if (pend_r && (key_rdata == value_r)) begin
          hit_nxt   = last_r;
          pend_nxt  = 1'b0;
          state_nxt = fuvt_pkg::ST_HIT_RD;
        end else if (!pend_r && !issue) begin
          state_nxt = fuvt_pkg::ST_NEW;
        end
      end
      fuvt_pkg::ST_HIT_RD: begin
        state_nxt = fuvt_pkg::ST_HIT_CHK;
      end
      fuvt_pkg::ST_HIT_CHK: begin
        if (rep_rdata == fuvt_pkg::MARK_UNIQUE) begin
          rep_we    = 1'b1;
          rep_waddr = hit_r;
          rep_wdata = fuvt_pkg::MARK_REPEATED;
          if (is_head && is_tail) begin
            nonempty_nxt = 1'b0;
          end else if (is_head) begin
            head_nxt = nxt_rdata;
          end else if (is_tail) begin
            tail_nxt = prv_rdata;
          end else begin
            nxt_we    = 1'b1;
            nxt_waddr = prv_rdata;
            nxt_wdata = nxt_rdata;
            prv_we    = 1'b1;
            prv_waddr = nxt_rdata;
            prv_wdata = prv_rdata;
          end
        end
        state_nxt = fuvt_pkg::ST_OUT_RD;
      end
      fuvt_pkg::ST_NEW: begin
        if (used_r < CAP_C) begin
          key_we   = 1'b1;
          rep_we   = 1'b1;
          used_nxt = used_r + CW'(1);
          if (!nonempty_r) begin
            head_nxt     = new_idx;
            tail_nxt     = new_idx;
            nonempty_nxt = 1'b1;
          end else begin
            nxt_we   = 1'b1;
            prv_we   = 1'b1;
            tail_nxt = new_idx;
          end
        end else begin
          dropped_nxt = 1'b1;
        end
        state_nxt = fuvt_pkg::ST_OUT_RD;
      end
      fuvt_pkg::ST_OUT_RD: begin
        key_raddr = head_r;
        state_nxt = fuvt_pkg::ST_OUT;
      end
      fuvt_pkg::ST_OUT: begin
        flags.valid = 1'b1;
        state_nxt   = fuvt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fuvt_pkg::ST_IDLE;
      end
    endcase

    first_value = nonempty_r ? key_rdata : '0;
  end

endmodule

`default_nettype wire

// ===== design/first_unique_value_tracker_top.sv =====
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// input     | start, busy        | in_value
// result    | out_valid (strobe) | out_first_value, out_has_unique,
//           |                    | out_dropped_full
//
// a request is taken on a rising edge with start high and busy low
// the key store is searched one entry a cycle; a repeat that is found is
// marked and unlinked from the order list if still unique, a new value is
// appended or, with a full table, dropped; then the list head is read out
// reset (rst_n low, synchronous) empties the table and the order list at once
// the result is shown for one cycle with out_valid; it cannot be stalled
`default_nettype none

module first_unique_value_tracker_top #(
  parameter int CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] in_value,
  output logic             busy,
  output logic             out_valid,
  output logic [31:0]      out_first_value,
  output logic             out_has_unique,
  output logic             out_dropped_full
);

  localparam int IW = $clog2(CAPACITY);

  // key store ports
  logic                        key_we;
  logic [IW-1:0]               key_waddr;
  logic [fuvt_pkg::KEY_W-1:0]  key_wdata;
  logic [IW-1:0]               key_raddr;
  logic [fuvt_pkg::KEY_W-1:0]  key_rdata;
  // repeat mark ports
  logic                        rep_we;
  logic [IW-1:0]               rep_waddr;
  logic                        rep_wdata;
  logic [IW-1:0]               rep_raddr;
  logic                        rep_rdata;
  // next link ports
  logic                        nxt_we;
  logic [IW-1:0]               nxt_waddr;
  logic [IW-1:0]               nxt_wdata;
  logic [IW-1:0]               nxt_raddr;
  logic [IW-1:0]               nxt_rdata;
  // prev link ports
  logic                        prv_we;
  logic [IW-1:0]               prv_waddr;
  logic [IW-1:0]               prv_wdata;
  logic [IW-1:0]               prv_raddr;
  logic [IW-1:0]               prv_rdata;

  fuvt_pkg::res_flags_t        flags;

  // sequencer: scan, unlink or append, then read the list head
  fuvt_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .value       (in_value),
    .busy        (busy),
    .first_value (out_first_value),
    .flags       (flags),
    .key_we      (key_we),
    .key_waddr   (key_waddr),
    .key_wdata   (key_wdata),
    .key_raddr   (key_raddr),
    .key_rdata   (key_rdata),
    .rep_we      (rep_we),
    .rep_waddr   (rep_waddr),
    .rep_wdata   (rep_wdata),
    .rep_raddr   (rep_raddr),
    .rep_rdata   (rep_rdata),
    .nxt_we      (nxt_we),
    .nxt_waddr   (nxt_waddr),
    .nxt_wdata   (nxt_wdata),
    .nxt_raddr   (nxt_raddr),
    .nxt_rdata   (nxt_rdata),
    .prv_we      (prv_we),
    .prv_waddr   (prv_waddr),
    .prv_wdata   (prv_wdata),
    .prv_raddr   (prv_raddr),
    .prv_rdata   (prv_rdata)
  );

  // stored keys, written once when an entry is allocated
  fuvt_ram #(
    .WIDTH (fuvt_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // unique / repeated mark; entries at or above the fill count are unused
  fuvt_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_rep_ram (
    .clk   (clk),
    .we    (rep_we),
    .waddr (rep_waddr),
    .wdata (rep_wdata),
    .raddr (rep_raddr),
    .rdata (rep_rdata)
  );

  // successor links of the order list
  fuvt_ram #(
    .WIDTH (IW),
    .DEPTH (CAPACITY)
  ) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  // predecessor links of the order list
  fuvt_ram #(
    .WIDTH (IW),
    .DEPTH (CAPACITY)
  ) u_prv_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (prv_raddr),
    .rdata (prv_rdata)
  );

  // result flags to ports
  assign out_valid        = flags.valid;
  assign out_has_unique   = flags.has_unique;
  assign out_dropped_full = flags.dropped_full;

endmodule

`default_nettype wire

// ===== design/fuvt_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module fuvt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_first_value,
  input wire logic        out_has_unique
);

  // result only appears while a request is in flight
  `FUVT_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy)
  // an accepted request makes the block busy
  `FUVT_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  // strobe lasts a single cycle
  `FUVT_ASSERT_NXT(a_strobe_one, clk, rst_n, out_valid, !out_valid)
  // no unique value reads as zero
  `FUVT_ASSERT_IMP(a_zero_empty, clk, rst_n, out_valid && !out_has_unique,
                   out_first_value == 32'd0)

endmodule

bind first_unique_value_tracker_top fuvt_checker u_fuvt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_first_value (out_first_value),
  .out_has_unique  (out_has_unique)
);

`default_nettype wire
